[rtl/core/slab_pkg.sv]
package slab_pkg;

  localparam int NUM_PAGES    = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int NUM_CLASSES  = 9;
  localparam int MIN_SIZE     = 8;
  localparam int MAX_SIZE     = 1 << (NUM_CLASSES - 1);

  localparam int ADDR_W   = 48;
  localparam int PAGE_W   = 7;                   // page number incl. empty mark
  localparam int PIDX_W   = 6;                   // page ram index
  localparam int OFF_W    = 12;                  // byte offset within a page
  localparam int SLOT_W   = 9;                   // slot index within a page
  localparam int LINK_W   = 10;                  // slot link incl. end mark
  localparam int CLS_W    = 4;
  localparam int SIDX_W   = PIDX_W + SLOT_W;     // slot ram index

  localparam logic [PAGE_W-1:0] NO_PAGE = PAGE_W'(NUM_PAGES);
  localparam logic [LINK_W-1:0] NO_SLOT = '1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_PAGES = 3'd2;
  localparam logic [2:0] ST_BAD_PTR  = 3'd3;
  localparam logic [2:0] ST_NOT_FND  = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_POOL_PAGES = 1'b1;

  typedef struct packed {
    logic [PAGE_W-1:0] next;
    logic [CLS_W-1:0]  cls;
    logic [LINK_W-1:0] slot_head;
  } page_word_t;

  typedef struct packed {
    logic              wen;
    logic [PIDX_W-1:0] waddr;
    page_word_t        wdata;
    logic [PIDX_W-1:0] raddr;
  } page_req_t;

  typedef struct packed {
    logic              wen;
    logic [SIDX_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [SIDX_W-1:0] raddr;
  } slot_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_DRAW, S_PAGE_RD, S_PAGE_WAIT, S_SLOT_WAIT,
    S_FREE_PAGE, S_WALK_RD, S_WALK_CHK, S_WALK_FIX, S_COMMIT, S_DONE
  } state_t;

  // ceil(log2(size)) for size in range: bit length of size-1
  function automatic logic [CLS_W-1:0] class_of(input logic [9:0] size);
    logic [9:0]       sm1;
    logic [CLS_W-1:0] c;
    sm1 = size - 10'd1;
    c = '0;
    for (int b = 0; b < 10; b++) begin
      if (sm1[b]) c = CLS_W'(b + 1);
    end
    return c;
  endfunction

  function automatic logic [SLOT_W-1:0] slots_of(input logic [CLS_W-1:0] cls);
    logic [OFF_W-1:0] n;
    n = OFF_W'(PAGE_BYTES - HEADER_BYTES) >> cls;
    return n[SLOT_W-1:0];
  endfunction

endpackage

[rtl/core/slab_size_class_allocator.sv]
// Alloc steps: decode, page read, page wait, slot wait; free: decode, page check, commit.
// Drawing a fresh page initializes the link of each of its slots (15 to 510) in turn,
// through the single write port of the slot-link memory.
// A free of a full page not at the head of its class full list walks that list.
// One transaction at a time; in_ready rises in the cycle after the result is registered.
// Reset (synchronous, active high) empties all class lists and the fresh-page count.
module slab_size_class_allocator import slab_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              config_write,
  input  logic              config_index,
  input  logic [ADDR_W-1:0] config_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [9:0]        size,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] object_address,
  output logic [2:0]        status
);

  logic [ADDR_W-1:0] pool_base;
  logic [PAGE_W-1:0] pool_pages;
  page_req_t         page_req;
  page_word_t        page_rdata;
  slot_req_t         slot_req;
  logic [LINK_W-1:0] slot_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      pool_pages <= PAGE_W'(NUM_PAGES);
    end else if (config_write) begin
      case (config_index)
        REG_POOL_BASE:  pool_base  <= config_data;
        REG_POOL_PAGES: pool_pages <= config_data[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  slab_ctrl u_ctrl (
    .clk, .rst, .pool_base, .pool_pages,
    .in_valid, .in_ready, .command, .size, .address,
    .out_valid, .out_ready, .object_address, .status,
    .page_req, .page_rdata, .slot_req, .slot_rdata
  );

  slab_page_ram u_page_ram (.clk, .req(page_req), .rdata(page_rdata));

  slab_slot_ram u_slot_ram (.clk, .req(slot_req), .rdata(slot_rdata));

  // a failed transaction never returns an address
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> object_address == '0)
    else $error("nonzero address on failure");

  // only one transaction in flight
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

[rtl/core/slab_page_ram.sv]
module slab_page_ram import slab_pkg::*; (
  input  logic       clk,
  input  page_req_t  req,
  output page_word_t rdata
);

  page_word_t mem [NUM_PAGES];

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.wen) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end

endmodule

[rtl/core/slab_slot_ram.sv]
module slab_slot_ram import slab_pkg::*; (
  input  logic              clk,
  input  slot_req_t         req,
  output logic [LINK_W-1:0] rdata
);

  logic [LINK_W-1:0] mem [NUM_PAGES * (1 << SLOT_W)];

  always_ff @(posedge clk) begin
    if (req.wen) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end

endmodule

[rtl/core/slab_ctrl.sv]
module slab_ctrl import slab_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] pool_base,
  input  logic [PAGE_W-1:0] pool_pages,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [9:0]        size,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] object_address,
  output logic [2:0]        status,
  output page_req_t         page_req,
  input  page_word_t        page_rdata,
  output slot_req_t         slot_req,
  input  logic [LINK_W-1:0] slot_rdata
);

  state_t state, state_next;

  logic              cmd;
  logic [9:0]        size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CLS_W-1:0]  cls;
  logic [PAGE_W-1:0] pg;
  logic [PAGE_W-1:0] cur;
  logic [PAGE_W-1:0] steps;
  logic [SLOT_W-1:0] slot;
  logic [OFF_W-1:0]  page_off;
  logic [SLOT_W-1:0] cnt;
  logic              eager;
  logic              full;
  page_word_t        pword;
  page_word_t        cword;
  logic [ADDR_W-1:0] res_addr;
  logic [2:0]        res_status;
  logic [PAGE_W-1:0] nfp;
  logic [PAGE_W-1:0] free_head [NUM_CLASSES];
  logic [PAGE_W-1:0] full_head [NUM_CLASSES];

  // decode-stage terms
  logic [PAGE_W-1:0] avail;
  logic              fresh_ok;
  logic              size_bad;
  logic [CLS_W-1:0]  dec_cls;
  logic [ADDR_W-1:0] off;
  logic              ptr_bad;

  assign avail    = (pool_pages > NO_PAGE) ? NO_PAGE : pool_pages;
  assign fresh_ok = nfp < avail;
  assign size_bad = (size_r < 10'(MIN_SIZE)) || (size_r > 10'(MAX_SIZE));
  assign dec_cls  = class_of(size_r);
  assign off      = addr_r - pool_base;
  assign ptr_bad  = (off[ADDR_W-1:OFF_W] >= (ADDR_W-OFF_W)'(nfp)) ||
                    (off[OFF_W-1:0] < OFF_W'(HEADER_BYTES));

  // free-page checks on the page word just read
  logic [OFF_W-1:0] fd;
  logic [OFF_W-1:0] fmask;
  logic [OFF_W-1:0] fslot;
  logic             free_bad;

  assign fd       = page_off - OFF_W'(HEADER_BYTES);
  assign fmask    = (OFF_W'(1) << page_rdata.cls) - OFF_W'(1);
  assign fslot    = fd >> page_rdata.cls;
  assign free_bad = ((fd & fmask) != '0) ||
                    (fslot >= OFF_W'(slots_of(page_rdata.cls)));

  // allocation result terms
  logic [SLOT_W-1:0] draw_last;
  logic [OFF_W-1:0]  obj_off;
  logic              page_fills;

  assign draw_last  = slots_of(cls) - SLOT_W'(1);
  assign obj_off    = OFF_W'(HEADER_BYTES) + OFF_W'({8'd0, slot} << cls);
  assign page_fills = slot_rdata == NO_SLOT;

  assign in_ready = state == S_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (cmd == CMD_ALLOC) begin
          if (size_bad) state_next = S_DONE;
          else if (free_head[dec_cls] != NO_PAGE) state_next = S_PAGE_RD;
          else if (fresh_ok) state_next = S_DRAW;
          else state_next = S_DONE;
        end else begin
          state_next = ptr_bad ? S_DONE : S_FREE_PAGE;
        end
      end
      S_DRAW:      if (cnt == draw_last) state_next = eager ? S_DONE : S_PAGE_RD;
      S_PAGE_RD:   state_next = S_PAGE_WAIT;
      S_PAGE_WAIT: state_next = S_SLOT_WAIT;
      S_SLOT_WAIT: begin
        if (page_fills && pword.next == NO_PAGE && fresh_ok) state_next = S_DRAW;
        else state_next = S_DONE;
      end
      S_FREE_PAGE: begin
        if (free_bad) state_next = S_DONE;
        else if (page_rdata.slot_head != NO_SLOT) state_next = S_COMMIT;
        else if (full_head[page_rdata.cls] == pg) state_next = S_COMMIT;
        else state_next = S_WALK_RD;
      end
      S_WALK_RD:   state_next = (cur == NO_PAGE) ? S_DONE : S_WALK_CHK;
      S_WALK_CHK: begin
        if (page_rdata.next == pg) state_next = S_WALK_FIX;
        else if (steps == PAGE_W'(NUM_PAGES)) state_next = S_DONE;
        else state_next = S_WALK_RD;
      end
      S_WALK_FIX:  state_next = S_COMMIT;
      S_COMMIT:    state_next = S_DONE;
      S_DONE:      if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    page_req = '0;
    slot_req = '0;
    case (state)
      S_DECODE:    page_req.raddr = off[OFF_W+PIDX_W-1:OFF_W];
      S_DRAW: begin
        page_req.wen   = cnt == '0;
        page_req.waddr = pg[PIDX_W-1:0];
        page_req.wdata = '{next: NO_PAGE, cls: cls, slot_head: '0};
        slot_req.wen   = 1'b1;
        slot_req.waddr = {pg[PIDX_W-1:0], cnt};
        slot_req.wdata = (cnt == draw_last) ? NO_SLOT : LINK_W'(cnt + SLOT_W'(1));
      end
      S_PAGE_RD:   page_req.raddr = pg[PIDX_W-1:0];
      S_PAGE_WAIT: slot_req.raddr = {pg[PIDX_W-1:0], page_rdata.slot_head[SLOT_W-1:0]};
      S_SLOT_WAIT: begin
        page_req.wen   = 1'b1;
        page_req.waddr = pg[PIDX_W-1:0];
        page_req.wdata = '{next: page_fills ? full_head[cls] : pword.next,
                           cls: cls, slot_head: slot_rdata};
      end
      S_WALK_RD:   page_req.raddr = cur[PIDX_W-1:0];
      S_WALK_FIX: begin
        page_req.wen   = 1'b1;
        page_req.waddr = cur[PIDX_W-1:0];
        page_req.wdata = '{next: pword.next, cls: cword.cls, slot_head: cword.slot_head};
      end
      S_COMMIT: begin
        page_req.wen   = 1'b1;
        page_req.waddr = pg[PIDX_W-1:0];
        page_req.wdata = '{next: full ? free_head[cls] : pword.next,
                           cls: pword.cls, slot_head: LINK_W'(slot)};
        slot_req.wen   = 1'b1;
        slot_req.waddr = {pg[PIDX_W-1:0], slot};
        slot_req.wdata = pword.slot_head;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      nfp       <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_head[c] <= NO_PAGE;
        full_head[c] <= NO_PAGE;
      end
    end else begin
      state <= state_next;
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_DECODE: begin
          if (cmd == CMD_ALLOC && !size_bad && free_head[dec_cls] == NO_PAGE && fresh_ok)
            nfp <= nfp + PAGE_W'(1);
        end
        S_DRAW: if (cnt == draw_last) free_head[cls] <= pg;
        S_SLOT_WAIT: begin
          if (page_fills) begin
            free_head[cls] <= pword.next;
            full_head[cls] <= pg;
            if (pword.next == NO_PAGE && fresh_ok) nfp <= nfp + PAGE_W'(1);
          end
        end
        S_FREE_PAGE: begin
          if (!free_bad && page_rdata.slot_head == NO_SLOT &&
              full_head[page_rdata.cls] == pg)
            full_head[page_rdata.cls] <= page_rdata.next;
        end
        S_COMMIT: if (full) free_head[cls] <= pg;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd    <= command;
        size_r <= size;
        addr_r <= address;
      end
      S_DECODE: begin
        cnt    <= '0;
        eager  <= 1'b0;
        res_addr <= '0;
        if (cmd == CMD_ALLOC) begin
          cls <= dec_cls;
          pg  <= (free_head[dec_cls] != NO_PAGE) ? free_head[dec_cls] : nfp;
          if (size_bad) res_status <= ST_BAD_SIZE;
          else if (free_head[dec_cls] == NO_PAGE && !fresh_ok) res_status <= ST_NO_PAGES;
          else res_status <= ST_OK;
        end else begin
          pg         <= {1'b0, off[OFF_W+PIDX_W-1:OFF_W]};
          page_off   <= off[OFF_W-1:0];
          res_status <= ptr_bad ? ST_BAD_PTR : ST_OK;
        end
      end
      S_DRAW:      cnt <= cnt + SLOT_W'(1);
      S_PAGE_WAIT: begin
        pword <= page_rdata;
        slot  <= page_rdata.slot_head[SLOT_W-1:0];
      end
      S_SLOT_WAIT: begin
        res_addr <= pool_base + {29'd0, pg, obj_off};
        if (page_fills && pword.next == NO_PAGE && fresh_ok) begin
          pg    <= nfp;
          cnt   <= '0;
          eager <= 1'b1;
        end
      end
      S_FREE_PAGE: begin
        pword <= page_rdata;
        cls   <= page_rdata.cls;
        slot  <= fslot[SLOT_W-1:0];
        full  <= page_rdata.slot_head == NO_SLOT;
        cur   <= full_head[page_rdata.cls];
        steps <= '0;
        if (free_bad) res_status <= ST_BAD_PTR;
      end
      S_WALK_RD:   if (cur == NO_PAGE) res_status <= ST_NOT_FND;
      S_WALK_CHK: begin
        // keep the predecessor in cur once the page is found
        cword <= page_rdata;
        if (page_rdata.next != pg) cur <= page_rdata.next;
        steps <= steps + PAGE_W'(1);
        if (page_rdata.next != pg && steps == PAGE_W'(NUM_PAGES)) res_status <= ST_NOT_FND;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          object_address <= res_addr;
          status         <= res_status;
        end
      end
      default: ;
    endcase
  end

endmodule

[tb/tb_slab_size_class_allocator.sv]
module tb_slab_size_class_allocator;
  import slab_pkg::*;

  localparam int SLOT_CAP = PAGE_BYTES / MIN_SIZE;
  localparam int LIMIT    = 3000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              config_write = 1'b0;
  logic              config_index = REG_POOL_BASE;
  logic [ADDR_W-1:0] config_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = CMD_ALLOC;
  logic [9:0]        size = '0;
  logic [ADDR_W-1:0] address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ADDR_W-1:0] object_address;
  logic [2:0]        status;

  slab_size_class_allocator dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic              cmd;
    logic [9:0]        sz;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        st;
  } reply_t;

  // pending requests and expected replies
  request_t          req_q[$];
  reply_t            reply_q[$];
  logic [ADDR_W-1:0] live_q[$];   // addresses handed out, for realistic frees

  // allocator shadow state
  logic [ADDR_W-1:0] m_base;
  logic [6:0]        m_pages;
  int unsigned       m_fresh;
  int unsigned       m_free_head[NUM_CLASSES];
  int unsigned       m_full_head[NUM_CLASSES];
  int unsigned       m_next[NUM_PAGES];
  int unsigned       m_cls[NUM_PAGES];
  int unsigned       m_shead[NUM_PAGES];
  int unsigned       m_link[NUM_PAGES*SLOT_CAP];

  int  errors = 0;
  int  n_ok = 0, n_bad = 0, n_sent = 0;
  bit  quiet = 1'b0;
  int  cycles = 0;
  int  in_gap = 0, out_gap = 0;

  localparam int unsigned END_SLOT = 1023;

  function automatic int unsigned slot_count(int unsigned c);
    return (PAGE_BYTES - HEADER_BYTES) >> c;
  endfunction

  function automatic bit take_page(int unsigned c, output int unsigned pg);
    int unsigned avail, n;
    avail = (m_pages > NUM_PAGES) ? NUM_PAGES : m_pages;
    n = slot_count(c);
    pg = m_fresh;
    if (m_fresh >= avail) return 1'b0;
    m_fresh++;
    m_next[pg] = NUM_PAGES;
    m_cls[pg] = c;
    m_shead[pg] = 0;
    for (int i = 0; i < n; i++) m_link[pg*SLOT_CAP+i] = (i + 1 < n) ? i + 1 : END_SLOT;
    return 1'b1;
  endfunction

  function automatic reply_t predict_alloc(int unsigned sz);
    reply_t r;
    int unsigned c, p, slot;
    r = '0;
    if (sz < MIN_SIZE || sz > MAX_SIZE || sz == 0) begin r.st = ST_BAD_SIZE; return r; end
    c = 0;
    while ((1 << c) < sz) c++;
    if (slot_count(c) == 0) begin r.st = ST_BAD_SIZE; return r; end
    if (m_free_head[c] == NUM_PAGES) begin
      if (!take_page(c, p)) begin r.st = ST_NO_PAGES; return r; end
      m_free_head[c] = p;
    end
    p = m_free_head[c];
    slot = m_shead[p];
    m_shead[p] = m_link[p*SLOT_CAP+slot];
    r.addr = m_base + ADDR_W'(p) * PAGE_BYTES + HEADER_BYTES + (ADDR_W'(slot) << c);
    r.st = ST_OK;
    if (m_shead[p] == END_SLOT) begin
      m_free_head[c] = m_next[p];
      m_next[p] = m_full_head[c];
      m_full_head[c] = p;
      if (m_free_head[c] == NUM_PAGES && take_page(c, p)) m_free_head[c] = p;
    end
    return r;
  endfunction

  function automatic reply_t predict_free(logic [ADDR_W-1:0] a);
    reply_t r;
    logic [ADDR_W-1:0] off, pg, in_page, d;
    int unsigned p, c, slot, cur, steps;
    r = '0;
    off = a - m_base;
    pg = off / PAGE_BYTES;
    in_page = off % PAGE_BYTES;
    if (pg >= m_fresh || in_page < HEADER_BYTES) begin r.st = ST_BAD_PTR; return r; end
    p = 32'(pg);
    c = m_cls[p];
    d = in_page - HEADER_BYTES;
    if ((d & ((ADDR_W'(1) << c) - 1)) != 0) begin r.st = ST_BAD_PTR; return r; end
    slot = 32'(d >> c);
    if (slot >= slot_count(c)) begin r.st = ST_BAD_PTR; return r; end
    if (m_shead[p] == END_SLOT) begin
      cur = m_full_head[c];
      if (cur == p) m_full_head[c] = m_next[p];
      else begin
        steps = 0;
        while (cur != NUM_PAGES && m_next[cur] != p && steps < NUM_PAGES) begin
          cur = m_next[cur];
          steps++;
        end
        if (cur == NUM_PAGES || m_next[cur] != p) begin r.st = ST_NOT_FND; return r; end
        m_next[cur] = m_next[p];
      end
      m_next[p] = m_free_head[c];
      m_free_head[c] = p;
    end
    m_link[p*SLOT_CAP+slot] = m_shead[p];
    m_shead[p] = slot;
    r.st = ST_OK;
    return r;
  endfunction

  // driver: presents queued requests, predicts at acceptance
  always @(posedge clk) begin
    reply_t r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        r = (command == CMD_FREE) ? predict_free(address) : predict_alloc(size);
        if (r.st == ST_OK && command == CMD_ALLOC) live_q.push_back(r.addr);
        reply_q.push_back(r);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_valid <= 1'b1;
          command <= req_q[0].cmd;
          size <= req_q[0].sz;
          address <= req_q[0].addr;
          void'(req_q.pop_front());
          if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 8);
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks replies, random backpressure
  always @(posedge clk) begin
    reply_t e;
    cycles++;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("unexpected transaction: object_address=%h status=%0d", object_address, status);
          errors++;
        end else begin
          e = reply_q.pop_front();
          if (object_address !== e.addr) begin
            $error("object_address expected %h actual %h", e.addr, object_address);
            errors++;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            errors++;
          end
          if (e.st == ST_OK) n_ok++; else n_bad++;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 8);
      end
    end
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_req(logic cmd, logic [9:0] sz, logic [ADDR_W-1:0] a);
    request_t q;
    q.cmd = cmd; q.sz = sz; q.addr = a;
    req_q.push_back(q);
  endtask

  task automatic drain();
    while (req_q.size() > 0 || in_valid || reply_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ADDR_W-1:0] v);
    @(posedge clk);
    config_write <= 1'b1;
    config_index <= idx;
    config_data <= v;
    @(posedge clk);
    config_write <= 1'b0;
    if (idx == REG_POOL_BASE) m_base = v; else m_pages = v[6:0];
  endtask

  // reset the shadow state to match the block after reset (only at start)
  task automatic shadow_reset();
    m_base = '0; m_pages = 7'd64; m_fresh = 0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      m_free_head[i] = NUM_PAGES; m_full_head[i] = NUM_PAGES;
    end
  endtask

  // random mixed phase; mostly allocs and frees of live objects
  task automatic random_phase(int n);
    int k;
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) push_req(CMD_ALLOC, 10'($urandom_range(8, 256)), '0);
      else if (k < 50) push_req(CMD_ALLOC, 10'($urandom), '0);
      else if (k < 85 && live_q.size() > 0) begin
        k = $urandom_range(0, live_q.size() - 1);
        a = live_q[k];
        live_q.delete(k);
        push_req(CMD_FREE, 10'($urandom), a);
      end else if (k < 92 && live_q.size() > 0)
        push_req(CMD_FREE, '0, live_q[$urandom_range(0, live_q.size()-1)] + $urandom_range(1, 7));
      else push_req(CMD_FREE, '0, {$urandom, $urandom});
      drain_if_deep();
    end
    drain();
  endtask

  task automatic drain_if_deep();
    while (req_q.size() > 40) @(posedge clk);
  endtask

  initial begin
    shadow_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: size extremes, bad frees, small pool exhaustion
    write_reg(REG_POOL_PAGES, 7'd3);
    push_req(CMD_ALLOC, 10'd0, '0);
    push_req(CMD_ALLOC, 10'd7, '0);
    push_req(CMD_ALLOC, 10'd1023, '0);
    push_req(CMD_ALLOC, 10'd257, '0);
    push_req(CMD_FREE, '0, '1);
    push_req(CMD_ALLOC, 10'd8, '0);
    push_req(CMD_ALLOC, 10'd256, '0);
    push_req(CMD_ALLOC, 10'd9, '0);
    push_req(CMD_FREE, '0, 48'd0);
    push_req(CMD_FREE, '0, 48'd16);
    push_req(CMD_FREE, '0, 48'd17);
    push_req(CMD_FREE, '0, 48'd16);   // double free
    push_req(CMD_FREE, '0, 48'd4095);
    for (int i = 0; i < 12; i++) push_req(CMD_ALLOC, 10'd256, '0); // more 256-byte allocs; the page is not filled
    drain();
    live_q.delete();

    // several pool settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_POOL_BASE, '1 << 12); write_reg(REG_POOL_PAGES, 7'd127); end
        1: begin write_reg(REG_POOL_BASE, 48'h1234_5678_9abc); write_reg(REG_POOL_PAGES, 7'd64); end
        2: begin write_reg(REG_POOL_BASE, '1); write_reg(REG_POOL_PAGES, 7'd1); end
        default: begin
          write_reg(REG_POOL_BASE, {$urandom, $urandom});
          write_reg(REG_POOL_PAGES, 7'($urandom));
        end
      endcase
      if (ph == 7) quiet = 1'b1;
      random_phase(210);
    end

    $display("Covered %0d transactions: %0d ok, %0d with error status,", n_sent, n_ok, n_bad);
    $display("over eight pool settings with size, pointer and exhaustion cases.");
    if (errors == 0 && reply_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
